FILE: sv/prle_pkg.sv
// Shared types and constants of the palette run-length pixel decoder.
// Used by prle_ctrl, prle_dpath and palette_rle_pixel_decoder; no dependencies.
package prle_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned TOTAL_W  = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // Command byte modes; phase reuses the same codes, with the zero code meaning
   // that the decoder awaits a command byte.
   localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INDEX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PAIR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ALPHA = 2'd3;
   localparam logic [MODE_W-1:0] PHASE_CMD  = MODE_ZERO;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'd255;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_INDEX = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_TOTAL   = 1'd1;

   typedef enum logic {
      ST_BYTE,    // take input bytes
      ST_ZRUN     // emit a transparent run, input held
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic emit_zero;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic zero_start;
      logic zero_end;
   } sts_type;

endpackage

FILE: sv/prle_ctrl.sv
// Controller of the palette run-length pixel decoder: byte intake versus
// transparent-run emission. Depends on prle_pkg.
module prle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  prle_pkg::sts_type sts,
   output prle_pkg::cmd_type cmd,
   output logic              in_ready
);

   prle_pkg::state_type state_ff;
   prle_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prle_pkg::ST_BYTE: begin
            if (req_tvalid && sts.slot_free && sts.zero_start) begin
               state_in = prle_pkg::ST_ZRUN;
            end
         end
         prle_pkg::ST_ZRUN: begin
            if (sts.slot_free && sts.zero_end) begin
               state_in = prle_pkg::ST_BYTE;
            end
         end
         default: state_in = prle_pkg::ST_BYTE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         prle_pkg::ST_BYTE: begin
            in_ready      = sts.slot_free;
            cmd.take_byte = req_tvalid && sts.slot_free;
         end
         prle_pkg::ST_ZRUN: begin
            cmd.emit_zero = sts.slot_free;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prle_pkg::ST_BYTE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_zrun_no_intake: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prle_pkg::ST_ZRUN) |-> (!in_ready && !cmd.take_byte))
      else $error("byte taken during transparent run");

   a_zrun_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_byte && sts.zero_start) |=> (state_ff == prle_pkg::ST_ZRUN))
      else $error("transparent run command did not start a run");

   a_zrun_exit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_zero && sts.zero_end) |=> (state_ff == prle_pkg::ST_BYTE))
      else $error("transparent run did not end");

endmodule

FILE: sv/prle_dpath.sv
// Datapath of the palette run-length pixel decoder: run state, pixel counter,
// configuration registers and output register. Depends on prle_pkg.
module prle_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  prle_pkg::cmd_type                     cmd,
   output prle_pkg::sts_type                     sts,
   input  logic [prle_pkg::BYTE_W-1:0]           stream_byte,
   input  logic                                  csr_we,
   input  logic [prle_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [prle_pkg::TOTAL_W-1:0]          csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [prle_pkg::BYTE_W-1:0]           rsp_color_index,
   output logic [prle_pkg::BYTE_W-1:0]           rsp_alpha,
   output logic                                  rsp_image_last,
   output logic                                  rsp_run_last
);

   logic [prle_pkg::BYTE_W-1:0]  default_index_ff, default_index_in;
   logic [prle_pkg::TOTAL_W-1:0] pixel_total_ff, pixel_total_in;
   logic [prle_pkg::MODE_W-1:0]  phase_ff, phase_in;
   logic [prle_pkg::COUNT_W-1:0] run_ff, run_in;
   logic                         pair_ff, pair_in;
   logic [prle_pkg::BYTE_W-1:0]  held_ff, held_in;
   logic                         clip_ff, clip_in;
   logic [prle_pkg::COUNT_W-1:0] zcount_ff, zcount_in;
   logic [prle_pkg::TOTAL_W-1:0] done_ff, done_in;
   logic                         valid_ff, valid_in;
   logic [prle_pkg::BYTE_W-1:0]  index_ff, index_in;
   logic [prle_pkg::BYTE_W-1:0]  alpha_ff, alpha_in;
   logic                         img_last_ff, img_last_in;
   logic                         run_last_ff, run_last_in;

   logic [prle_pkg::COUNT_W-1:0] cmd_count;
   logic [prle_pkg::MODE_W-1:0]  cmd_mode;
   logic [prle_pkg::TOTAL_W:0]   done_next;
   logic                         img_end;
   logic                         pix_emit;

   assign cmd_count = stream_byte[prle_pkg::BYTE_W-1:prle_pkg::MODE_W];
   assign cmd_mode  = stream_byte[prle_pkg::MODE_W-1:0];
   assign done_next = {1'b0, done_ff} + {{prle_pkg::TOTAL_W{1'b0}}, 1'b1};
   assign img_end   = done_next >= {1'b0, pixel_total_ff};

   assign sts.slot_free  = !valid_ff || rsp_ready;
   assign sts.zero_start = (phase_ff == prle_pkg::PHASE_CMD) && (cmd_count != '0)
                           && (cmd_mode == prle_pkg::MODE_ZERO);
   assign sts.zero_end   = (zcount_ff == prle_pkg::COUNT_W'(1)) || img_end;

   always_comb begin
      default_index_in = default_index_ff;
      pixel_total_in   = pixel_total_ff;
      if (csr_we) begin
         case (csr_index)
            prle_pkg::CSR_DEFAULT_INDEX: default_index_in = csr_wdata[prle_pkg::BYTE_W-1:0];
            prle_pkg::CSR_PIXEL_TOTAL:   pixel_total_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      run_in      = run_ff;
      pair_in     = pair_ff;
      held_in     = held_ff;
      clip_in     = clip_ff;
      zcount_in   = zcount_ff;
      done_in     = done_ff;
      pix_emit    = 1'b0;
      index_in    = index_ff;
      alpha_in    = alpha_ff;
      img_last_in = img_last_ff;
      run_last_in = run_last_ff;

      if (cmd.take_byte) begin
         if (phase_ff == prle_pkg::PHASE_CMD) begin
            if (cmd_count != '0) begin
               if (cmd_mode == prle_pkg::MODE_ZERO) begin
                  zcount_in = cmd_count;
               end else begin
                  phase_in = cmd_mode;
                  run_in   = cmd_count;
                  pair_in  = 1'b0;
                  clip_in  = 1'b0;
               end
            end
         end else if ((phase_ff == prle_pkg::MODE_PAIR) && !pair_ff) begin
            // Hold the index byte until its alpha arrives.
            held_in = stream_byte;
            pair_in = 1'b1;
         end else begin
            pair_in = 1'b0;
            run_in  = run_ff - prle_pkg::COUNT_W'(1);
            if (run_ff == prle_pkg::COUNT_W'(1)) begin
               phase_in = prle_pkg::PHASE_CMD;
            end
            if (!clip_ff) begin
               pix_emit    = 1'b1;
               run_last_in = 1'b1;
               clip_in     = img_end;
               case (phase_ff)
                  prle_pkg::MODE_INDEX: begin
                     index_in = stream_byte;
                     alpha_in = prle_pkg::ALPHA_OPAQUE;
                  end
                  prle_pkg::MODE_PAIR: begin
                     index_in = held_ff;
                     alpha_in = stream_byte;
                  end
                  default: begin
                     index_in = default_index_ff;
                     alpha_in = stream_byte;
                  end
               endcase
            end
         end
      end else if (cmd.emit_zero) begin
         pix_emit    = 1'b1;
         index_in    = '0;
         alpha_in    = '0;
         run_last_in = sts.zero_end;
         zcount_in   = zcount_ff - prle_pkg::COUNT_W'(1);
      end

      if (pix_emit) begin
         img_last_in = img_end;
         done_in     = img_end ? '0 : done_next[prle_pkg::TOTAL_W-1:0];
      end
   end

   assign valid_in = pix_emit || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         default_index_ff <= '0;
         pixel_total_ff   <= prle_pkg::TOTAL_W'(1);
         phase_ff         <= prle_pkg::PHASE_CMD;
         run_ff           <= '0;
         pair_ff          <= 1'b0;
         held_ff          <= '0;
         clip_ff          <= 1'b0;
         zcount_ff        <= '0;
         done_ff          <= '0;
         valid_ff         <= 1'b0;
      end else begin
         default_index_ff <= default_index_in;
         pixel_total_ff   <= pixel_total_in;
         phase_ff         <= phase_in;
         run_ff           <= run_in;
         pair_ff          <= pair_in;
         held_ff          <= held_in;
         clip_ff          <= clip_in;
         zcount_ff        <= zcount_in;
         done_ff          <= done_in;
         valid_ff         <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff    <= index_in;
      alpha_ff    <= alpha_in;
      img_last_ff <= img_last_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_color_index = index_ff;
   assign rsp_alpha       = alpha_ff;
   assign rsp_image_last  = img_last_ff;
   assign rsp_run_last    = run_last_ff;

   a_payload_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != prle_pkg::PHASE_CMD) |-> (run_ff != '0))
      else $error("payload phase with no bytes left");

   a_no_pair_at_cmd: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == prle_pkg::PHASE_CMD) |-> !pair_ff)
      else $error("half pair pending while awaiting a command");

   a_zrun_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_zero |-> (zcount_ff != '0))
      else $error("transparent pixel emitted past run count");

   a_counter_restart: assert property (@(posedge clock) disable iff (reset)
      (pix_emit && img_end) |=> (done_ff == '0 && rsp_image_last && rsp_valid))
      else $error("pixel counter did not restart at image end");

endmodule

FILE: sv/palette_rle_pixel_decoder.sv
// Top level of the palette run-length pixel decoder: stream ports and the
// controller/datapath pair. Depends on prle_pkg, prle_ctrl and prle_dpath.
//
// Decodes a run-length pixel body, one byte per item on req_, into pixels
// (palette index and alpha) on rsp_. A command byte holds a count in bits 7..2
// and a mode in bits 1..0: mode 0 gives count transparent pixels, mode 1 is
// followed by count index bytes (alpha 255), mode 2 by count index/alpha pairs,
// mode 3 by count alpha bytes that take the default_index register. A command
// with count 0 is consumed silently. Pixels are counted against pixel_total;
// the pixel that completes an image carries rsp_tlast, the counter restarts,
// and the rest of a run that crosses the image end is consumed without output.
// rsp_tuser marks the last pixel caused by one input byte. Rate: one input byte
// per cycle while rsp_ tready stays high, set by the single output register; a
// mode 0 command holds req_tready low while the controller produces its run (up
// to 63 pixels) one pixel per cycle while rsp_tready is high. Registers are
// written through csr_we/csr_index/csr_wdata (index 0 default_index, index 1
// pixel_total), by the user only while idle; the block does not enforce it.
module palette_rle_pixel_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // input byte stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] stream_byte
   // pixel stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [7:0] color_index, [15:8] alpha
   output logic                                rsp_tlast,   // image_last
   output logic [0:0]                          rsp_tuser,   // [0] run_last
   // configuration writes
   input  logic                                csr_we,
   input  logic [prle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prle_pkg::TOTAL_W-1:0]        csr_wdata
);

   prle_pkg::cmd_type cmd;
   prle_pkg::sts_type sts;

   logic [prle_pkg::BYTE_W-1:0] pix_index;
   logic [prle_pkg::BYTE_W-1:0] pix_alpha;
   logic                        pix_run_last;

   // Sequence byte intake and transparent runs.
   prle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .cmd        (cmd),
      .in_ready   (req_tready)
   );

   // Hold run state, pixel counter, registers and the output item.
   prle_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .stream_byte     (req_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_color_index (pix_index),
      .rsp_alpha       (pix_alpha),
      .rsp_image_last  (rsp_tlast),
      .rsp_run_last    (pix_run_last)
   );

   // Pack the pixel fields, index in the low byte.
   assign rsp_tdata = {pix_alpha, pix_index};
   assign rsp_tuser = pix_run_last;

endmodule

FILE: tb/sv/palette_rle_pixel_decoder_tb.sv
// Self-checking testbench for palette_rle_pixel_decoder: streams encoded body
// bytes, predicts the pixels in its own decoder model and checks every pixel.
// Depends on prle_pkg and the palette_rle_pixel_decoder RTL only.
module palette_rle_pixel_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT      = 19;      // idle cycles per hundred, each side
   localparam int HOLD_CYCLES   = 300;     // one long pixel-side hold-off
   localparam int LINGER_CYCLES = 16;      // settle time after the last pixel
   localparam int LIMIT_CYCLES  = 400000;  // watchdog
   localparam int PHASES        = 7;       // register settings in the random part
   localparam int PHASE_ITEMS   = 30;      // body bytes per setting
   localparam int HOLD_PHASE    = 3;
   localparam int STEADY_PHASE  = 4;      // no idling on either side
   localparam int DIR_ROWS      = 25;

   typedef struct packed {
      logic [7:0] color_index;
      logic [7:0] alpha;
      logic       image_last;
      logic       run_last;
   } pixel_type;

   // How a directed row is checked: by the decoder model, or against a
   // typed expectation of no pixel or exactly one pixel.
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_NONE,
      ROW_ONE
   } row_check_type;

   typedef struct packed {
      logic [7:0]    stream_byte;
      row_check_type check;
      pixel_type     pix;
   } dir_row_type;

   localparam pixel_type NO_PIXEL = '0;

   // ------------------------------------------------------------------
   // DUT signals
   // ------------------------------------------------------------------
   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;    // [7:0] stream_byte
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [15:0]                    rsp_tdata;    // [7:0] color_index, [15:8] alpha
   logic                           rsp_tlast;    // image_last
   logic [0:0]                     rsp_tuser;    // [0] run_last
   logic                           csr_we;
   logic [prle_pkg::CSR_IDX_W-1:0] csr_index;
   logic [prle_pkg::TOTAL_W-1:0]   csr_wdata;

   palette_rle_pixel_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Directed table, run right after reset: default_index 0, pixel_total 1.
   // With a one-pixel image every emitted pixel closes the image, so each
   // pixel carries image_last and run_last and a run stops after one pixel.
   // ------------------------------------------------------------------
   dir_row_type dir_table [DIR_ROWS] = '{
      '{8'h00, ROW_NONE,  NO_PIXEL},                        // zero count, mode 0
      '{8'h03, ROW_NONE,  NO_PIXEL},                        // zero count, mode 3
      '{8'hFC, ROW_ONE,   '{8'h00, 8'h00, 1'b1, 1'b1}},     // 63 transparent, clipped
      '{8'h05, ROW_NONE,  NO_PIXEL},                        // index run of 1
      '{8'hFF, ROW_ONE,   '{8'hFF, 8'hFF, 1'b1, 1'b1}},
      '{8'h06, ROW_NONE,  NO_PIXEL},                        // pair run of 1
      '{8'hA5, ROW_NONE,  NO_PIXEL},                        // index half of a pair
      '{8'h5A, ROW_ONE,   '{8'hA5, 8'h5A, 1'b1, 1'b1}},
      '{8'h07, ROW_NONE,  NO_PIXEL},                        // alpha run of 1
      '{8'h00, ROW_ONE,   '{8'h00, 8'h00, 1'b1, 1'b1}},
      '{8'h09, ROW_NONE,  NO_PIXEL},                        // index run of 2
      '{8'h00, ROW_ONE,   '{8'h00, 8'hFF, 1'b1, 1'b1}},
      '{8'h80, ROW_NONE,  NO_PIXEL},                        // past image end: eaten
      '{8'h0A, ROW_NONE,  NO_PIXEL},                        // pair run of 2
      '{8'h11, ROW_NONE,  NO_PIXEL},
      '{8'h22, ROW_ONE,   '{8'h11, 8'h22, 1'b1, 1'b1}},
      '{8'h33, ROW_MODEL, NO_PIXEL},
      '{8'h44, ROW_MODEL, NO_PIXEL},
      '{8'h0F, ROW_NONE,  NO_PIXEL},                        // alpha run of 3
      '{8'hFF, ROW_ONE,   '{8'h00, 8'hFF, 1'b1, 1'b1}},
      '{8'h01, ROW_MODEL, NO_PIXEL},
      '{8'h7E, ROW_MODEL, NO_PIXEL},
      '{8'h04, ROW_ONE,   '{8'h00, 8'h00, 1'b1, 1'b1}},     // one transparent pixel
      '{8'h01, ROW_NONE,  NO_PIXEL},                        // zero count, mode 1
      '{8'h02, ROW_NONE,  NO_PIXEL}                         // zero count, mode 2
   };

   // ------------------------------------------------------------------
   // Decoder model state and register copies
   // ------------------------------------------------------------------
   logic [7:0]  cfg_default;
   logic [31:0] cfg_total;
   logic [1:0]  dec_phase;
   logic [5:0]  run_left;
   logic        pair_half;
   logic [7:0]  held_index;
   logic [31:0] pixels_done;
   logic        run_clipped;

   pixel_type fresh [$];          // pixels caused by the byte just decoded
   pixel_type pixel_queue [$];    // pixels still owed by the DUT

   int errors         = 0;
   int items_sent     = 0;
   int pixels_checked = 0;
   int images_done    = 0;
   int cur_phase      = -1;
   int cycle_count    = 0;

   // Count one pixel against the image; returns 1 when it closes the image.
   function automatic logic add_pixel(input logic [7:0] idx, input logic [7:0] a,
                                      input logic byte_done);
      pixel_type p;
      logic      img_end;
      img_end = ({1'b0, pixels_done} + 33'd1) >= {1'b0, cfg_total};
      p.color_index = idx;
      p.alpha       = a;
      p.image_last  = img_end;
      p.run_last    = byte_done | img_end;
      pixels_done   = img_end ? 32'd0 : pixels_done + 32'd1;
      fresh.push_back(p);
      return img_end;
   endfunction

   // Decode one body byte into fresh[].
   function automatic void decode_byte(input logic [7:0] b);
      logic [5:0] count;
      logic [1:0] mode;
      logic [7:0] idx;
      logic [7:0] a;
      logic       produce;
      fresh.delete();
      if (dec_phase == prle_pkg::PHASE_CMD) begin
         count = b[7:2];
         mode  = b[1:0];
         if (count == 6'd0)
            return;
         if (mode == prle_pkg::MODE_ZERO) begin
            // transparent run stops early at the image end
            for (int n = 0; n < count; n++) begin
               if (add_pixel(8'h00, 8'h00, n == count - 1))
                  break;
            end
            return;
         end
         dec_phase   = mode;
         run_left    = count;
         pair_half   = 1'b0;
         run_clipped = 1'b0;
         return;
      end

      produce = !run_clipped;
      case (dec_phase)
         prle_pkg::MODE_INDEX: begin
            idx = b;
            a   = prle_pkg::ALPHA_OPAQUE;
         end
         prle_pkg::MODE_PAIR: begin
            if (!pair_half) begin
               held_index = b;
               pair_half  = 1'b1;
               return;
            end
            pair_half = 1'b0;
            idx       = held_index;
            a         = b;
         end
         default: begin
            idx = cfg_default;
            a   = b;
         end
      endcase

      run_left = run_left - 6'd1;
      if (run_left == 6'd0)
         dec_phase = prle_pkg::PHASE_CMD;
      // bytes past the image end are still consumed, silently
      if (produce) begin
         if (add_pixel(idx, a, 1'b1))
            run_clipped = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d pixels still owed", $time, pixel_queue.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Pixel side: random tready, one long hold-off, check every pixel
   // ------------------------------------------------------------------
   initial begin
      int        hold_left;
      logic      hold_done;
      pixel_type got;
      pixel_type want;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser[0]};
            pixels_checked++;
            if (got.image_last === 1'b1)
               images_done++;
            if (pixel_queue.size() == 0) begin
               errors++;
               if (errors <= 50)
                  $display("%0t: unexpected pixel idx %h alpha %h image_last %b run_last %b",
                           $time, got.color_index, got.alpha, got.image_last, got.run_last);
            end else begin
               want = pixel_queue.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 50)
                     $display({"%0t: pixel mismatch: expected idx %h alpha %h image_last %b ",
                               "run_last %b, actual idx %h alpha %h image_last %b run_last %b"},
                              $time, want.color_index, want.alpha, want.image_last,
                              want.run_last, got.color_index, got.alpha, got.image_last,
                              got.run_last);
               end
            end
         end
         // pick tready for the next cycle
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && cur_phase == HOLD_PHASE) begin
            // back up the output so the decoder stalls its byte input
            hold_left  = HOLD_CYCLES;
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (cur_phase == STEADY_PHASE) || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------
   // Byte side
   // ------------------------------------------------------------------

   // Offer one byte, with random idle cycles first; return at its handshake.
   task automatic send_byte(input logic [7:0] b);
      while (cur_phase != STEADY_PHASE && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   // Send a byte and queue the pixels the model gives for it.
   task automatic feed(input logic [7:0] b);
      send_byte(b);
      decode_byte(b);
      foreach (fresh[i])
         pixel_queue.push_back(fresh[i]);
   endtask

   // One random chunk of body: mostly well-formed runs with random payload,
   // some zero counts, runs cut short, and loose noise bytes. Send no more
   // than budget bytes.
   task automatic send_sequence(input int budget);
      int         kind;
      int         payload;
      logic [5:0] count;
      logic [1:0] mode;
      kind  = $urandom_range(99);
      if (kind < 8) begin
         feed(8'($urandom_range(255)));
         return;
      end
      mode  = 2'($urandom_range(3));
      count = ($urandom_range(9) == 0) ? 6'd63 : 6'($urandom_range(1, 8));
      if (kind < 11)
         count = 6'd0;
      if (count == 6'd0 || mode == prle_pkg::MODE_ZERO)
         payload = 0;
      else if (mode == prle_pkg::MODE_PAIR)
         payload = 2 * count;
      else
         payload = count;
      // cut the payload short; the next command then lands inside the run
      if (kind < 17 && payload > 0)
         payload = $urandom_range(payload - 1);
      // stay within the byte budget, leaving the run open if needed
      if (payload > budget - 1)
         payload = budget - 1;
      feed({count, mode});
      repeat (payload)
         feed(8'($urandom_range(255)));
   endtask

   // Drop valid, wait for every owed pixel, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pixel_queue.size() != 0)
         @(posedge clock);
      repeat (LINGER_CYCLES)
         @(posedge clock);
   endtask

   // Write one register; the caller drops csr_we afterwards.
   task automatic write_reg(input logic [prle_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == prle_pkg::CSR_DEFAULT_INDEX)
         cfg_default = val[7:0];
      else
         cfg_total = val;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [7:0]  di;
      logic [31:0] pt;
      int          phase_goal;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      csr_we     <= 1'b0;
      csr_index  <= prle_pkg::CSR_DEFAULT_INDEX;
      csr_wdata  <= '0;
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      // model state after reset
      cfg_default = 8'h00;
      cfg_total   = 32'd1;
      dec_phase   = prle_pkg::PHASE_CMD;
      run_left    = 6'd0;
      pair_half   = 1'b0;
      held_index  = 8'h00;
      pixels_done = 32'd0;
      run_clipped = 1'b0;

      // Directed rows: advance the model on every row so its state tracks
      // the DUT, but hold the typed expectation where the row gives one.
      foreach (dir_table[r]) begin
         send_byte(dir_table[r].stream_byte);
         decode_byte(dir_table[r].stream_byte);
         case (dir_table[r].check)
            ROW_MODEL: begin
               foreach (fresh[i])
                  pixel_queue.push_back(fresh[i]);
            end
            ROW_ONE:
               pixel_queue.push_back(dir_table[r].pix);
            default: ;
         endcase
      end
      drain();

      // Random part, one register setting per phase. Pixel counts carry over
      // between phases, so a small total after a large one lands below the
      // count already reached.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin di = 8'hFF; pt = 32'd0; end            // every pixel closes an image
            1: begin di = 8'h5A; pt = 32'd40; end
            2: begin di = 8'($urandom_range(255)); pt = 32'd3; end
            3: begin di = 8'($urandom_range(255)); pt = 32'd9; end
            4: begin di = 8'hA5; pt = 32'd4294836225; end   // 65535 x 65535 pixels
            5: begin di = 8'($urandom_range(255)); pt = $urandom; end
            default: begin di = 8'h00; pt = 32'd1; end
         endcase
         if (p % 2 == 0) begin
            write_reg(prle_pkg::CSR_DEFAULT_INDEX, {24'd0, di});
            write_reg(prle_pkg::CSR_PIXEL_TOTAL, pt);
         end else begin
            write_reg(prle_pkg::CSR_PIXEL_TOTAL, pt);
            write_reg(prle_pkg::CSR_DEFAULT_INDEX, {24'd0, di});
         end
         csr_we    <= 1'b0;
         cur_phase  = p;
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal)
            send_sequence(phase_goal - items_sent);
         drain();
      end

      $display("Run covered %0d body bytes (directed rows plus random runs of all modes)",
               items_sent);
      $display("over %0d register settings; %0d pixels checked, %0d images closed.",
               PHASES + 1, pixels_checked, images_done);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
